// ----- src/dfal_pkg.sv -----
// ----------------------------------------------------------------------------
// dfal_pkg: shared types and tables of the DFA lexer
// Automaton tables, keyword table, the per-symbol step function and the
// structs passed between the lexer core and its result queue.
// ----------------------------------------------------------------------------
package dfal_pkg;

  localparam int KW_COUNT       = 28;
  localparam int CNT_W          = 6;
  localparam int LINE_W         = 16;
  localparam int STATE_W        = 7;
  localparam int KIND_W         = 6;
  localparam int RES_FIFO_DEPTH = 8;
  localparam int RES_PER_ITEM   = 3;

  localparam logic [CNT_W-1:0]   MAX_LEN_RESET = 6'd50;
  localparam logic [CNT_W-1:0]   CNT_MAX       = 6'd63;
  localparam logic [LINE_W-1:0]  LINE_TOP      = 16'hFFFF;
  localparam logic [LINE_W-1:0]  LINE_FIRST    = 16'd1;

  // Automaton states with a special meaning.
  localparam logic [STATE_W-1:0] ST_START       = 7'd0;
  localparam logic [STATE_W-1:0] ST_COMMENT_NL  = 7'd2;
  localparam logic [STATE_W-1:0] ST_EOF         = 7'd3;
  localparam logic [STATE_W-1:0] ST_NEWLINE     = 7'd9;
  localparam logic [STATE_W-1:0] ST_SPACE_END   = 7'd28;
  localparam logic [STATE_W-1:0] ST_FUNID       = 7'd46;
  localparam logic [STATE_W-1:0] ST_FIELDID     = 7'd49;
  localparam logic [STATE_W-1:0] ST_TRAP        = 7'd127;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_FUNID   = 6'd21;
  localparam logic [KIND_W-1:0] K_FIELDID = 6'd30;
  localparam logic [KIND_W-1:0] K_EOF     = 6'd57;
  localparam logic [KIND_W-1:0] K_ERR     = 6'd59;

  // Return codes of one step.
  typedef enum logic [1:0] {
    RET_CONSUME = 2'd0,
    RET_REPLAY  = 2'd1,
    RET_REPLAY2 = 2'd2
  } ret_t;

  // Finality codes.
  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_FINAL = 2'd1,
    FIN_BACK1 = 2'd2,
    FIN_BACK2 = 2'd3
  } fin_t;

  // Keywords, right-justified: first character in the highest used byte.
  localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
    "else", "with", "parameters", "output", "int", "read", "write",
    "return", "then", "real", "endwhile", "if", "type", "_main", "global",
    "endif", "endunion", "definetype", "as", "call", "record", "endrecord",
    "parameter", "end", "while", "union", "list", "input"};
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd10, 4'd6, 4'd3, 4'd4, 4'd5, 4'd6, 4'd4, 4'd4, 4'd8, 4'd2,
    4'd4, 4'd5, 4'd6, 4'd5, 4'd8, 4'd10, 4'd2, 4'd4, 4'd6, 4'd9, 4'd9, 4'd3,
    4'd5, 4'd5, 4'd4, 4'd5};
  localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
    6'd8, 6'd4, 6'd12, 6'd35, 6'd9, 6'd48, 6'd28, 6'd15, 6'd13, 6'd55, 6'd6,
    6'd1, 6'd7, 6'd5, 6'd38, 6'd37, 6'd29, 6'd17, 6'd39, 6'd3, 6'd25, 6'd47,
    6'd53, 6'd45, 6'd19, 6'd24, 6'd31, 6'd23};

  // Lexer context. The keyword mask stands in for the stored lexeme text:
  // bit i is set while the lexeme so far is a prefix of keyword i.
  typedef struct packed {
    logic [STATE_W-1:0]  state;
    logic [CNT_W-1:0]    count;
    logic [KW_COUNT-1:0] kmask;
    logic [LINE_W-1:0]   line;
    logic [LINE_W-1:0]   start_line;
    logic [7:0]          hold;
  } ctx_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [CNT_W-1:0]  len;
    logic              too_long;
    logic              done;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } out_item_t;

  typedef struct packed {
    ctx_t ctx;
    logic emit;
    res_t res;
    ret_t ret;
  } step_t;

  function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] s,
                                                 input logic [8:0] c);
    logic [7:0] ch;
    logic eoi, dg, lo, up, r27, bcd;
    logic [STATE_W-1:0] nx;
    ch  = c[7:0];
    eoi = c[8];
    dg  = !eoi && ch >= "0" && ch <= "9";
    lo  = !eoi && ch >= "a" && ch <= "z";
    up  = !eoi && ch >= "A" && ch <= "Z";
    r27 = !eoi && ch >= "2" && ch <= "7";
    bcd = !eoi && ch >= "b" && ch <= "d";
    nx  = ST_TRAP;
    unique case (s)
      7'd0: begin
        if (eoi) nx = ST_EOF;
        else if (dg) nx = 7'd29;
        else if (bcd) nx = 7'd47;
        else if (lo) nx = 7'd48;
        else begin
          unique case (ch)
            "%":   nx = 7'd1;
            "*":   nx = 7'd4;
            "&":   nx = 7'd5;
            "~":   nx = 7'd8;
            8'h0A: nx = 7'd9;
            "@":   nx = 7'd10;
            "[":   nx = 7'd13;
            "-":   nx = 7'd14;
            "+":   nx = 7'd15;
            "(":   nx = 7'd16;
            "=":   nx = 7'd17;
            ")":   nx = 7'd19;
            ";":   nx = 7'd20;
            ":":   nx = 7'd21;
            "!":   nx = 7'd22;
            "/":   nx = 7'd24;
            ".":   nx = 7'd25;
            "]":   nx = 7'd26;
            8'h09, " ": nx = 7'd27;
            "#":   nx = 7'd40;
            "_":   nx = 7'd43;
            ",":   nx = 7'd64;
            ">":   nx = 7'd54;
            "<":   nx = 7'd57;
            default: nx = ST_TRAP;
          endcase
        end
      end
      7'd1:  nx = eoi ? 7'd65 : (ch == 8'h0A ? 7'd2 : 7'd1);
      7'd5:  nx = (!eoi && ch == "&") ? 7'd6 : ST_TRAP;
      7'd6:  nx = (!eoi && ch == "&") ? 7'd7 : ST_TRAP;
      7'd10: nx = (!eoi && ch == "@") ? 7'd11 : ST_TRAP;
      7'd11: nx = (!eoi && ch == "@") ? 7'd12 : ST_TRAP;
      7'd17: nx = (!eoi && ch == "=") ? 7'd18 : ST_TRAP;
      7'd22: nx = (!eoi && ch == "=") ? 7'd23 : ST_TRAP;
      7'd27: nx = (!eoi && (ch == 8'h09 || ch == " ")) ? 7'd27 : 7'd28;
      7'd29: nx = dg ? 7'd29 : ((!eoi && ch == ".") ? 7'd30 : 7'd39);
      7'd30: nx = dg ? 7'd31 : 7'd38;
      7'd31: nx = dg ? 7'd32 : ST_TRAP;
      7'd32: nx = (!eoi && (ch == "E" || ch == "e")) ? 7'd33 : 7'd37;
      7'd33: nx = (!eoi && (ch == "+" || ch == "-")) ? 7'd34 : (dg ? 7'd35 : ST_TRAP);
      7'd34: nx = dg ? 7'd35 : ST_TRAP;
      7'd35: nx = dg ? 7'd36 : ST_TRAP;
      7'd40: nx = lo ? 7'd41 : ST_TRAP;
      7'd41: nx = lo ? 7'd41 : 7'd42;
      7'd43: nx = (lo || up) ? 7'd44 : ST_TRAP;
      7'd44: nx = (lo || up) ? 7'd44 : (dg ? 7'd45 : 7'd46);
      7'd45: nx = dg ? 7'd45 : 7'd46;
      7'd47: nx = lo ? 7'd48 : (r27 ? 7'd50 : 7'd53);
      7'd48: nx = lo ? 7'd48 : 7'd49;
      7'd50: nx = bcd ? 7'd50 : (r27 ? 7'd51 : 7'd52);
      7'd51: nx = r27 ? 7'd51 : 7'd52;
      7'd54: nx = (!eoi && ch == "=") ? 7'd55 : 7'd56;
      7'd57: nx = (!eoi && ch == "=") ? 7'd58 : ((!eoi && ch == "-") ? 7'd59 : 7'd63);
      7'd59: nx = (!eoi && ch == "-") ? 7'd60 : 7'd62;
      7'd60: nx = (!eoi && ch == "-") ? 7'd61 : (eoi ? ST_TRAP : 7'd69);
      default: nx = ST_TRAP;
    endcase
    return nx;
  endfunction

  function automatic fin_t finality(input logic [STATE_W-1:0] s);
    fin_t f;
    unique case (s)
      7'd2, 7'd3, 7'd4, 7'd7, 7'd8, 7'd9, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16,
      7'd18, 7'd19, 7'd20, 7'd21, 7'd23, 7'd24, 7'd25, 7'd26, 7'd64, 7'd36,
      7'd55, 7'd58, 7'd61: f = FIN_FINAL;
      7'd28, 7'd37, 7'd39, 7'd42, 7'd46, 7'd49, 7'd52, 7'd53, 7'd56, 7'd63,
      7'd65: f = FIN_BACK1;
      7'd38, 7'd62: f = FIN_BACK2;
      default: f = FIN_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [KIND_W-1:0] fixed_kind(input logic [STATE_W-1:0] s);
    logic [KIND_W-1:0] k;
    unique case (s)
      7'd2, 7'd65: k = 6'd58;
      7'd4:  k = 6'd54;
      7'd7:  k = 6'd32;
      7'd8:  k = 6'd10;
      7'd12: k = 6'd20;
      7'd13: k = 6'd50;
      7'd14: k = 6'd0;
      7'd15: k = 6'd46;
      7'd16: k = 6'd18;
      7'd18: k = 6'd36;
      7'd19: k = 6'd33;
      7'd20: k = 6'd14;
      7'd21: k = 6'd40;
      7'd23: k = 6'd41;
      7'd24: k = 6'd2;
      7'd25: k = 6'd26;
      7'd26: k = 6'd44;
      7'd64: k = 6'd22;
      7'd36, 7'd37: k = 6'd52;
      7'd38, 7'd39: k = 6'd51;
      7'd42: k = 6'd27;
      7'd52: k = 6'd16;
      7'd53: k = 6'd30;
      7'd55: k = 6'd42;
      7'd56: k = 6'd11;
      7'd58: k = 6'd43;
      7'd61: k = 6'd34;
      7'd62, 7'd63: k = 6'd49;
      default: k = K_ERR;
    endcase
    return k;
  endfunction

  // Narrow the keyword candidates by the character appended at position pos.
  function automatic logic [KW_COUNT-1:0] kw_step(input logic [KW_COUNT-1:0] mask,
                                                  input logic [CNT_W-1:0] pos,
                                                  input logic [7:0] ch);
    logic [KW_COUNT-1:0] m;
    logic [3:0] idx;
    m = mask;
    for (int i = 0; i < KW_COUNT; i++) begin
      idx = (KW_LEN[i] - 4'd1) - pos[3:0];
      if (pos >= {2'b00, KW_LEN[i]} || KW_TEXT[i][{idx, 3'b000} +: 8] != ch) begin
        m[i] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_COUNT-1:0] mask,
                                                input logic [CNT_W-1:0] len,
                                                input logic [KIND_W-1:0] dflt);
    logic [KIND_W-1:0] k;
    k = dflt;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (mask[i] && len == {2'b00, KW_LEN[i]}) k = KW_KIND[i];
    end
    return k;
  endfunction

  // One symbol through the automaton, including token emission and retract.
  function automatic step_t feed(input ctx_t cx, input logic [8:0] c,
                                 input logic [CNT_W-1:0] max_len);
    step_t o;
    logic [STATE_W-1:0] nx;
    fin_t fin;
    logic [CNT_W-1:0] len;
    logic eoi;
    eoi   = c[8];
    o     = '0;
    o.ctx = cx;
    o.ret = RET_CONSUME;
    nx    = advance(cx.state, c);
    fin   = finality(nx);
    len   = '0;
    if (nx == ST_TRAP) begin
      if (cx.count == '0) begin
        if (!eoi) begin
          o.ctx.hold  = c[7:0];
          o.ctx.kmask = kw_step(cx.kmask, cx.count, c[7:0]);
          o.ctx.count = cx.count + 6'd1;
        end
      end else begin
        o.ret = RET_REPLAY;
      end
      o.emit     = 1'b1;
      o.res.kind = K_ERR;
      o.res.line = cx.start_line;
      o.res.len  = o.ctx.count;
    end else begin
      if ((fin == FIN_NONE || fin == FIN_FINAL) && !eoi) begin
        o.ctx.hold  = c[7:0];
        o.ctx.kmask = kw_step(cx.kmask, cx.count, c[7:0]);
        if (cx.count < CNT_MAX) o.ctx.count = cx.count + 6'd1;
      end
      if (fin == FIN_NONE) begin
        o.ctx.state = nx;
      end else if (nx == ST_EOF) begin
        o.emit     = 1'b1;
        o.res.kind = K_EOF;
        o.res.line = cx.start_line;
        o.res.done = 1'b1;
        o.ctx.line = LINE_FIRST;
      end else begin
        len = o.ctx.count;
        if (fin == FIN_BACK2 && len != '0 && len < CNT_MAX) len = len - 6'd1;
        if (len >= max_len) begin
          o.emit         = 1'b1;
          o.res.kind     = K_ERR;
          o.res.line     = cx.start_line;
          o.res.len      = len;
          o.res.too_long = 1'b1;
        end else if (nx == ST_NEWLINE) begin
          if (o.ctx.line != LINE_TOP) o.ctx.line = o.ctx.line + 16'd1;
        end else if (nx != ST_SPACE_END) begin
          o.emit     = 1'b1;
          o.res.line = cx.start_line;
          o.res.len  = len;
          if (nx == ST_FUNID) o.res.kind = kw_kind(o.ctx.kmask, len, K_FUNID);
          else if (nx == ST_FIELDID) o.res.kind = kw_kind(o.ctx.kmask, len, K_FIELDID);
          else o.res.kind = fixed_kind(nx);
          if (nx == ST_COMMENT_NL && o.ctx.line != LINE_TOP) begin
            o.ctx.line = o.ctx.line + 16'd1;
          end
        end
        if (fin == FIN_BACK1) o.ret = RET_REPLAY;
        else if (fin == FIN_BACK2) o.ret = RET_REPLAY2;
      end
    end
    if (nx == ST_TRAP || fin != FIN_NONE) begin
      o.ctx.state      = ST_START;
      o.ctx.count      = '0;
      o.ctx.kmask      = '1;
      o.ctx.start_line = o.ctx.line;
    end
    return o;
  endfunction

endpackage

// ----- src/dfal_result_fifo.sv -----
// ----------------------------------------------------------------------------
// dfal_result_fifo: token result queue
// Takes up to three results per cycle in order and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module dfal_result_fifo
  import dfal_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  wr_count,
  input  out_item_t [RES_PER_ITEM-1:0] wr_item,
  output logic                        room,
  output logic                        out_valid,
  input  logic                        out_ready,
  output out_item_t                   out_item
);

  localparam int PTR_W = $clog2(RES_FIFO_DEPTH);

  out_item_t          mem [RES_FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     fill;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign out_item  = mem[rd_ptr];
  assign room      = fill <= (PTR_W+1)'(RES_FIFO_DEPTH - RES_PER_ITEM);

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_PER_ITEM; k++) begin
      if (2'(k) < wr_count) mem[wr_ptr + PTR_W'(k)] <= wr_item[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill + (PTR_W+1)'(wr_count) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ----- src/dfa_lexer_with_retract.sv -----
// ----------------------------------------------------------------------------
// dfa_lexer_with_retract: tokenizer automaton with keyword lookup
// Latency: a result may be taken in the cycle after its character is taken.
// Throughput: one character per cycle while the result queue has room for
// three results; a character yields up to three, drained one a cycle while m_tready is high.
// Reset: synchronous; automaton at start, line counters at 1, limit 50.
// ----------------------------------------------------------------------------
// Each accepted character is run through up to three chained copies of the
// step logic in the same cycle: the first from the current context, the
// second replays the character (or the held lexeme character) from the start
// state after a retract, the third replays the character after a two
// character retract. A step from the start state always consumes its symbol,
// so three steps cover every case.
module dfa_lexer_with_retract
  import dfal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Source characters.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] input_char
  input  logic        s_tuser,   // [0] end_of_input
  // Tokens.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [5:0] token_kind, [21:6] token_line,
                                 // [27:22] lexeme_length, [31:28] zero
  output logic [1:0]  m_tuser,   // [0] too_long, [1] stream_done
  output logic        m_tlast,   // last result caused by one character
  // Configuration: max_lexeme_length.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  ctx_t                         ctx;
  ctx_t                         ctx_next;
  logic [CNT_W-1:0]             max_len;
  logic                         s_fire;
  logic [8:0]                   sym;
  logic [8:0]                   sym2;
  step_t                        f1;
  step_t                        f2;
  step_t                        f3;
  logic                         e2;
  logic                         e3;
  logic [1:0]                   wcnt;
  out_item_t [RES_PER_ITEM-1:0] witem;
  logic                         room;
  out_item_t                    head;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign s_fire    = s_tvalid && s_tready;

  // End of input is its own symbol, above every byte value.
  assign sym  = s_tuser ? 9'h100 : {1'b0, s_tdata};
  assign sym2 = (f1.ret == RET_REPLAY2) ? {1'b0, f1.ctx.hold} : sym;

  assign f1 = feed(ctx, sym, max_len);
  assign f2 = feed(f1.ctx, sym2, max_len);
  assign f3 = feed(f2.ctx, sym, max_len);

  assign e2 = (f1.ret != RET_CONSUME) && f2.emit;
  assign e3 = (f1.ret == RET_REPLAY2) && f3.emit;

  always_comb begin
    unique case (f1.ret)
      RET_CONSUME: ctx_next = f1.ctx;
      RET_REPLAY:  ctx_next = f2.ctx;
      default:     ctx_next = f3.ctx;
    endcase
  end

  // Pack the emitted results in order and mark the last of them.
  always_comb begin
    wcnt  = '0;
    witem = '0;
    if (f1.emit) begin
      witem[wcnt].res = f1.res;
      wcnt = wcnt + 2'd1;
    end
    if (e2) begin
      witem[wcnt].res = f2.res;
      wcnt = wcnt + 2'd1;
    end
    if (e3) begin
      witem[wcnt].res = f3.res;
      wcnt = wcnt + 2'd1;
    end
    if (wcnt != '0) witem[wcnt - 2'd1].last = 1'b1;
    if (!s_fire) wcnt = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.state      <= ST_START;
      ctx.count      <= '0;
      ctx.kmask      <= '1;
      ctx.line       <= LINE_FIRST;
      ctx.start_line <= LINE_FIRST;
      ctx.hold       <= '0;
      max_len        <= MAX_LEN_RESET;
    end else begin
      if (s_fire) ctx <= ctx_next;
      if (cfg_valid && cfg_ready) max_len <= cfg_data;
    end
  end

  dfal_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_count  (wcnt),
    .wr_item   (witem),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (head)
  );

  assign m_tdata = {4'b0000, head.res.len, head.res.line, head.res.kind};
  assign m_tuser = {head.res.done, head.res.too_long};
  assign m_tlast = head.last;

`ifndef NO_ASSERTIONS
  // Away from the start state a lexeme always holds at least one character.
  a_state_count: assert property (@(posedge clk) disable iff (rst)
    ctx.state != ST_START |-> ctx.count != '0)
    else $error("non-start state with empty lexeme");

  // A replayed symbol from the start state is always consumed.
  a_replay_consumed: assert property (@(posedge clk) disable iff (rst)
    (s_fire && f1.ret != RET_CONSUME) |-> f2.ret == RET_CONSUME)
    else $error("replay did not consume");

  // The line counter never drops to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctx.line != '0 && ctx.start_line != '0)
    else $error("line counter zero");

  // A taken configuration write shows in the limit in the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> max_len == $past(cfg_data))
    else $error("limit not updated");
`endif

endmodule
